@@ rtl/core/imm_pkg.sv @@
// Shared constants, types and helpers for the integer matrix multiply block.
// No dependencies; every other file of the block but imm_ram imports this package.
`timescale 1ns / 1ps

package imm_pkg;

  // Sizes
  localparam int MAX_DIM    = 8;
  localparam int VALUE_BITS = 16;
  localparam int SUM_W      = 32;
  localparam int IDX_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_W      = $clog2(MAX_DIM + 1);

  // External field widths
  localparam int KEY_IDX_W = 3;
  localparam int OUT_IDX_W = 3;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [CFG_W-1:0] RESET_DIM = CFG_W'(4);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS = 1'b0,
    CFG_COLS = 1'b1
  } cfg_idx_e;

  // Request kinds
  typedef enum logic {
    REQ_KEY = 1'b0,
    REQ_MSG = 1'b1
  } req_kind_e;

  // One message element with its key row, as queued for the back end
  typedef struct packed {
    logic signed [VALUE_BITS-1:0]          value;
    logic [MAX_DIM-1:0][VALUE_BITS-1:0]    key;
    logic                                  row_done;
    logic                                  mat_done;
    logic [IDX_W-1:0]                      row_idx;
    logic [DIM_W-1:0]                      cols;
  } imm_entry_t;

  typedef struct packed {
    logic       valid;
    imm_entry_t entry;
  } imm_push_t;

  typedef struct packed {
    logic       valid;
    imm_entry_t entry;
  } imm_head_t;

  // Out-of-range dimension values map to 1 or MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (int'(d) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(d);
    end
    return r;
  endfunction

endpackage

@@ rtl/core/imm_if.sv @@
// Request and result channel interfaces of the integer matrix multiply block.
// Depends on imm_pkg for field widths.
`timescale 1ns / 1ps

interface imm_req_if;
  import imm_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [KEY_IDX_W-1:0]         key_row;
  logic [KEY_IDX_W-1:0]         key_col;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output req_type, output key_row, output key_col,
                  output value, input ready);
  modport sink   (input valid, input req_type, input key_row, input key_col,
                  input value, output ready);
endinterface

interface imm_res_if;
  import imm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OUT_IDX_W-1:0]    out_row;
  logic [OUT_IDX_W-1:0]    out_col;
  logic signed [SUM_W-1:0] product;
  logic                    last_in_row;
  logic                    last_of_matrix;

  modport source (output valid, output out_row, output out_col, output product,
                  output last_in_row, output last_of_matrix, input ready);
  modport sink   (input valid, input out_row, input out_col, input product,
                  input last_in_row, input last_of_matrix, output ready);
endinterface

@@ rtl/core/integer_matrix_multiply.sv @@
// Top level of the integer matrix multiply block: configuration registers and
// the front end, queue and back end. Depends on imm_pkg, imm_if and all imm_* modules.
`timescale 1ns / 1ps

// Multiplies a message matrix, fed one element per request in row-major order,
// by a key matrix held in the block and written by key requests beforehand.
// Requests are taken one per cycle while the four-entry element queue has room;
// key writes go straight into the column RAMs, message elements are queued with
// their key row. The back end runs one multiply-accumulate over all columns per
// cycle, so elements flow at one per cycle. A finished row moves into a row
// buffer that drains one result per cycle while the result channel is ready and the
// next row accumulates; the element that ends a second row waits until that
// buffer is empty. A message element passes through the front-end stage register,
// the queue, the multiply stage register, the row buffer and the output register.
// Dimensions of 0 act as 1 and values above 8 act as 8; write them only while idle.

module integer_matrix_multiply (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [imm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [imm_pkg::CFG_W-1:0]     cfg_data_i,
  imm_req_if.sink                       req_i,
  imm_res_if.source                     res_o
);
  import imm_pkg::*;

  logic [CFG_W-1:0] rows_q;
  logic [CFG_W-1:0] cols_q;
  logic [DIM_W-1:0] rows;
  logic [DIM_W-1:0] cols;
  logic [CNT_W-1:0] fifo_cnt;
  imm_push_t        push;
  imm_head_t        head;
  logic             pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= RESET_DIM;
      cols_q <= RESET_DIM;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROWS: rows_q <= cfg_data_i;
        CFG_COLS: cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign rows = clamp_dim(rows_q);
  assign cols = clamp_dim(cols_q);

  imm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .rows_i     (rows),
    .cols_i     (cols),
    .fifo_cnt_i (fifo_cnt),
    .push_o     (push)
  );

  imm_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .head_o (head),
    .pop_i  (pop),
    .cnt_o  (fifo_cnt)
  );

  imm_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .res_o  (res_o)
  );

endmodule

@@ rtl/core/imm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module imm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/imm_front.sv @@
// Front end: accepts requests, stores key elements, tracks the message position
// and queues each message element with its key row. Depends on imm_pkg, imm_if, imm_ram.
`timescale 1ns / 1ps

module imm_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  imm_req_if.sink                    req_i,
  input  logic [imm_pkg::DIM_W-1:0]  rows_i,
  input  logic [imm_pkg::DIM_W-1:0]  cols_i,
  input  logic [imm_pkg::CNT_W-1:0]  fifo_cnt_i,
  output imm_pkg::imm_push_t         push_o
);
  import imm_pkg::*;

  logic                               accept;
  logic                               key_wr;
  logic                               msg_acc;
  logic                               room;
  logic [DIM_W-1:0]                   pos_next;
  logic [DIM_W-1:0]                   row_next;
  logic                               row_done;
  logic                               mat_done;
  logic [IDX_W-1:0]                   pos_q, pos_d;
  logic [IDX_W-1:0]                   row_q, row_d;
  logic                               s1_valid_q;
  logic signed [VALUE_BITS-1:0]       s1_value_q;
  logic                               s1_row_done_q;
  logic                               s1_mat_done_q;
  logic [IDX_W-1:0]                   s1_row_idx_q;
  logic [DIM_W-1:0]                   s1_cols_q;
  logic [MAX_DIM-1:0][VALUE_BITS-1:0] key_row_data;

  // Take a request only when the queue surely has a slot for it
  assign room     = (int'(fifo_cnt_i) + int'(s1_valid_q)) < FIFO_DEPTH;
  assign req_i.ready = room;
  assign accept   = req_i.valid && room;
  assign key_wr   = accept && (req_i.req_type == REQ_KEY)
                    && (int'(req_i.key_row) < MAX_DIM) && (int'(req_i.key_col) < MAX_DIM);
  assign msg_acc  = accept && (req_i.req_type == REQ_MSG);

  // Key store: one column per RAM, all read at the current element position
  for (genvar j = 0; j < MAX_DIM; j++) begin : g_key
    imm_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (MAX_DIM)
    ) u_key_ram (
      .clk_i   (clk_i),
      .we_i    (key_wr && (int'(req_i.key_col) == j)),
      .waddr_i (IDX_W'(req_i.key_row)),
      .wdata_i (req_i.value),
      .raddr_i (pos_q),
      .rdata_o (key_row_data[j])
    );
  end

  // Row and matrix completion
  assign pos_next = DIM_W'(pos_q) + DIM_W'(1);
  assign row_next = DIM_W'(row_q) + DIM_W'(1);
  assign row_done = pos_next >= rows_i;
  assign mat_done = row_next >= rows_i;

  always_comb begin
    pos_d = pos_q;
    row_d = row_q;
    if (msg_acc) begin
      if (row_done) begin
        pos_d = '0;
        row_d = mat_done ? '0 : IDX_W'(row_next);
      end else begin
        pos_d = IDX_W'(pos_next);
      end
    end
  end

  // Position counters and stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      row_q      <= row_d;
      s1_valid_q <= msg_acc;
    end
  end

  // Element fields are registered to line up with the registered key row read
  always_ff @(posedge clk_i) begin
    if (msg_acc) begin
      s1_value_q    <= req_i.value;
      s1_row_done_q <= row_done;
      s1_mat_done_q <= mat_done;
      s1_row_idx_q  <= row_q;
      s1_cols_q     <= cols_i;
    end
  end

  assign push_o.valid          = s1_valid_q;
  assign push_o.entry.value    = s1_value_q;
  assign push_o.entry.key      = key_row_data;
  assign push_o.entry.row_done = s1_row_done_q;
  assign push_o.entry.mat_done = s1_mat_done_q;
  assign push_o.entry.row_idx  = s1_row_idx_q;
  assign push_o.entry.cols     = s1_cols_q;

endmodule

@@ rtl/core/imm_fifo.sv @@
// Short queue of message elements between front and back end.
// Depends on imm_pkg.
`timescale 1ns / 1ps

module imm_fifo (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  imm_pkg::imm_push_t         push_i,
  output imm_pkg::imm_head_t         head_o,
  input  logic                       pop_i,
  output logic [imm_pkg::CNT_W-1:0]  cnt_o
);
  import imm_pkg::*;

  imm_entry_t       slot_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i.valid) begin
      wr_ptr_d = (int'(wr_ptr_q) == FIFO_DEPTH - 1) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (int'(rd_ptr_q) == FIFO_DEPTH - 1) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i.valid && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (!push_i.valid && do_pop) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      slot_q[wr_ptr_q] <= push_i.entry;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.entry = slot_q[rd_ptr_q];
  assign cnt_o        = cnt_q;

endmodule

@@ rtl/core/imm_back.sv @@
// Back end: per-column multiply lanes, row accumulators, a row buffer for
// draining finished rows and the output register. Depends on imm_pkg, imm_if.
`timescale 1ns / 1ps

module imm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  imm_pkg::imm_head_t  head_i,
  output logic                pop_o,
  imm_res_if.source           res_o
);
  import imm_pkg::*;

  // Multiply stage
  logic                         a_valid_q;
  logic signed [SUM_W-1:0]      prod_q [MAX_DIM];
  logic signed [SUM_W-1:0]      prod_d [MAX_DIM];
  logic                         a_row_done_q;
  logic                         a_mat_done_q;
  logic [IDX_W-1:0]             a_row_idx_q;
  logic [DIM_W-1:0]             a_cols_q;
  logic                         a_go;
  logic                         pop;

  // Accumulate stage
  logic signed [SUM_W-1:0]      acc_q [MAX_DIM];
  logic signed [SUM_W-1:0]      acc_d [MAX_DIM];
  logic signed [SUM_W-1:0]      sum [MAX_DIM];

  // Row buffer
  logic signed [SUM_W-1:0]      bank_q [MAX_DIM];
  logic [DIM_W-1:0]             bank_left_q;
  logic [IDX_W-1:0]             bank_idx_q;
  logic [IDX_W-1:0]             bank_row_q;
  logic                         bank_mat_q;
  logic                         emit;
  logic                         bank_load;

  // Output register
  logic                         out_valid_q;
  logic [OUT_IDX_W-1:0]         out_row_q;
  logic [OUT_IDX_W-1:0]         out_col_q;
  logic signed [SUM_W-1:0]      out_prod_q;
  logic                         out_last_q;
  logic                         out_mat_q;

  // A finishing row waits until the row buffer is drained
  assign a_go      = a_valid_q && (!a_row_done_q || (bank_left_q == '0));
  assign pop       = head_i.valid && (!a_valid_q || a_go);
  assign pop_o     = pop;
  assign bank_load = a_go && a_row_done_q;
  assign emit      = (bank_left_q != '0) && (!out_valid_q || res_o.ready);

  // One multiplier per column lane
  always_comb begin
    logic signed [SUM_W-1:0] v_ext;
    logic signed [SUM_W-1:0] k_ext;
    for (int j = 0; j < MAX_DIM; j++) begin
      v_ext     = SUM_W'(head_i.entry.value);
      k_ext     = SUM_W'($signed(head_i.entry.key[j]));
      prod_d[j] = v_ext * k_ext;
    end
  end

  // Accumulate the active columns; a finished row clears all of them
  always_comb begin
    for (int j = 0; j < MAX_DIM; j++) begin
      sum[j]   = (j < int'(a_cols_q)) ? acc_q[j] + prod_q[j] : acc_q[j];
      acc_d[j] = acc_q[j];
      if (a_go) begin
        acc_d[j] = a_row_done_q ? '0 : sum[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      bank_left_q <= '0;
      out_valid_q <= 1'b0;
      for (int j = 0; j < MAX_DIM; j++) begin
        acc_q[j] <= '0;
      end
    end else begin
      if (pop) begin
        a_valid_q <= 1'b1;
      end else if (a_go) begin
        a_valid_q <= 1'b0;
      end
      for (int j = 0; j < MAX_DIM; j++) begin
        acc_q[j] <= acc_d[j];
      end
      if (bank_load) begin
        bank_left_q <= a_cols_q;
      end else if (emit) begin
        bank_left_q <= bank_left_q - DIM_W'(1);
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (pop) begin
      for (int j = 0; j < MAX_DIM; j++) begin
        prod_q[j] <= prod_d[j];
      end
      a_row_done_q <= head_i.entry.row_done;
      a_mat_done_q <= head_i.entry.mat_done;
      a_row_idx_q  <= head_i.entry.row_idx;
      a_cols_q     <= head_i.entry.cols;
    end
    if (bank_load) begin
      for (int j = 0; j < MAX_DIM; j++) begin
        bank_q[j] <= sum[j];
      end
      bank_idx_q <= '0;
      bank_row_q <= a_row_idx_q;
      bank_mat_q <= a_mat_done_q;
    end else if (emit) begin
      bank_idx_q <= bank_idx_q + IDX_W'(1);
    end
    if (emit) begin
      out_row_q  <= OUT_IDX_W'(bank_row_q);
      out_col_q  <= OUT_IDX_W'(bank_idx_q);
      out_prod_q <= bank_q[bank_idx_q];
      out_last_q <= (bank_left_q == DIM_W'(1));
      out_mat_q  <= (bank_left_q == DIM_W'(1)) && bank_mat_q;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.out_row        = out_row_q;
  assign res_o.out_col        = out_col_q;
  assign res_o.product        = out_prod_q;
  assign res_o.last_in_row    = out_last_q;
  assign res_o.last_of_matrix = out_mat_q;

endmodule
